### design/lbrw_pkg.sv
// Shared types and constants for the longest bounded-range window block.
package lbrw_pkg;

  // Field widths and store depth.
  localparam int IDX_W = 10;
  localparam int VAL_W = 30;
  localparam int DEPTH = 1024;
  localparam logic [IDX_W:0] DEPTH_L = (IDX_W+1)'(DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

  // Item modes.
  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  // Input word.
  typedef struct packed {
    logic             mode;
    logic [IDX_W-1:0] element_index;
    logic [VAL_W-1:0] element_value;
    logic [IDX_W-1:0] query_left;
    logic [IDX_W-1:0] query_right;
  } in_word_t;

  // Result word.
  typedef struct packed {
    logic [IDX_W-1:0] window_start;
    logic [IDX_W-1:0] window_end;
  } out_word_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic wr_en;
    logic ld_query;
    logic rd_sel;
    logic init;
    logic step;
    logic commit;
    logic next;
    logic load_out;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic empty;
    logic more;
    logic fits;
    logic cont;
  } sts_t;

endpackage

### design/lbrw_datapath.sv
// Datapath: value store, window pointers, running min and max, best window.
module lbrw_datapath import lbrw_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  in_word_t         in_word,
  input  logic             cfg_wr_en,
  input  logic [VAL_W-1:0] cfg_wr_data,
  input  cmd_t             cmd,
  output sts_t             sts,
  output out_word_t        out_word
);

  logic [VAL_W-1:0] mem_r [DEPTH];
  logic [VAL_W-1:0] rd_data_r;
  logic [VAL_W-1:0] limit_r;
  logic [IDX_W-1:0] right_r, s_r, e_r, best_s_r, best_e_r;
  logic [VAL_W-1:0] lo_r, hi_r;
  logic             first_r;
  out_word_t        out_word_r;

  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] in_right;
  logic [VAL_W-1:0] nlo, nhi;
  logic [IDX_W-1:0] cur_len, best_len;
  logic [IDX_W:0]   j_next, rem;

  // Saturate the right end of a query to the last index.
  always_comb begin
    if ({1'b0, in_word.query_right} > {1'b0, LAST_IDX}) begin
      in_right = LAST_IDX;
    end else begin
      in_right = in_word.query_right;
    end
  end

  // Read address: window start, or the element after the current end.
  assign rd_addr = cmd.rd_sel ? (e_r + IDX_W'(1)) : s_r;

  // Store write and registered read.
  always_ff @(posedge clk) begin
    if (cmd.wr_en && ({1'b0, in_word.element_index} < DEPTH_L)) begin
      mem_r[in_word.element_index] <= in_word.element_value;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  // Candidate min and max with the freshly read element.
  assign nlo      = (rd_data_r < lo_r) ? rd_data_r : lo_r;
  assign nhi      = (rd_data_r > hi_r) ? rd_data_r : hi_r;
  assign cur_len  = e_r - s_r;
  assign best_len = best_e_r - best_s_r;
  assign j_next   = {1'b0, s_r} + (IDX_W+1)'(1);
  assign rem      = {1'b0, right_r} - j_next;

  // Status toward the controller.
  always_comb begin
    sts.empty = in_word.query_left > in_right;
    sts.more  = e_r < right_r;
    sts.fits  = (nhi - nlo) <= limit_r;
    sts.cont  = (j_next <= {1'b0, right_r}) && (best_e_r != right_r)
                && (rem > {1'b0, best_len});
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= '0;
    end else if (cfg_wr_en) begin
      limit_r <= cfg_wr_data;
    end
  end

  // First-window flag is control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r <= 1'b0;
    end else if (cmd.ld_query) begin
      first_r <= 1'b1;
    end else if (cmd.commit) begin
      first_r <= 1'b0;
    end
  end

  // Search registers.
  always_ff @(posedge clk) begin
    if (cmd.ld_query) begin
      right_r  <= in_right;
      s_r      <= in_word.query_left;
      best_s_r <= in_word.query_left;
      best_e_r <= in_word.query_left;
    end
    if (cmd.init) begin
      lo_r <= rd_data_r;
      hi_r <= rd_data_r;
      e_r  <= s_r;
    end
    if (cmd.step) begin
      lo_r <= nlo;
      hi_r <= nhi;
      e_r  <= e_r + IDX_W'(1);
    end
    // A strictly longer window replaces the best, so ties keep the earliest.
    if (cmd.commit && (first_r || (cur_len > best_len))) begin
      best_s_r <= s_r;
      best_e_r <= e_r;
    end
    if (cmd.next) begin
      s_r <= s_r + IDX_W'(1);
    end
    if (cmd.load_out) begin
      out_word_r.window_start <= best_s_r;
      out_word_r.window_end   <= best_e_r;
    end
  end

  assign out_word = out_word_r;

  // Checks.
  a_step_advances: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |=> e_r == $past(e_r) + IDX_W'(1))
    else $error("window end did not advance by one");

  a_out_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> out_word_r.window_start <= out_word_r.window_end)
    else $error("result window start beyond its end");

  a_commit_in_order: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> e_r >= s_r)
    else $error("window end before its start at commit");

endmodule

### design/lbrw_ctrl.sv
// Controller: sequences writes, the window search and the result handoff.
module lbrw_ctrl import lbrw_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  logic in_mode,
  output logic out_valid,
  input  logic out_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RS   = 3'd1;
  localparam logic [2:0] S_RI   = 3'd2;
  localparam logic [2:0] S_CK   = 3'd3;
  localparam logic [2:0] S_EV   = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;
  localparam logic [2:0] S_NX   = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  // Next state and commands.
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    in_ready      = 1'b0;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_mode == MODE_WRITE) begin
            cmd.wr_en = 1'b1;
          end else begin
            cmd.ld_query = 1'b1;
            state_nxt    = sts.empty ? S_DONE : S_RS;
          end
        end
      end
      S_RS: begin
        state_nxt = S_RI;
      end
      S_RI: begin
        cmd.init  = 1'b1;
        state_nxt = S_CK;
      end
      S_CK: begin
        if (sts.more) begin
          cmd.rd_sel = 1'b1;
          state_nxt  = S_EV;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_EV: begin
        if (sts.fits) begin
          cmd.step  = 1'b1;
          state_nxt = S_CK;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        cmd.commit = 1'b1;
        state_nxt  = S_NX;
      end
      S_NX: begin
        if (sts.cont) begin
          cmd.next  = 1'b1;
          state_nxt = S_RS;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  // Checks.
  a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> out_valid_r)
    else $error("loaded result not presented");

  a_load_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_ready))
    else $error("result overwritten before it was taken");

  a_query_searches: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.ld_query && !sts.empty) |=> state_r == S_RS)
    else $error("nonempty query did not start a search");

endmodule

### design/longest_bounded_range_window_core.sv
// Top level of the longest bounded-range window block.
// A write word is stored as it is accepted. A query walks its interval
// from each candidate start with a running min and max, reading the value
// store through its single read port. For each start it reads the start
// element, then reads and checks each following element until the walk
// reaches the right end or an element breaks the limit, and then commits
// the window. The search stops early once no later start can win, and the
// result is handed over once the output register is free.
// One word is worked on at a time; a finished result waits in an output
// register while the next word is accepted. The spread limit resets to zero.
module longest_bounded_range_window_core import lbrw_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_word_t         in_word,
  output logic             out_valid,
  input  logic             out_ready,
  output out_word_t        out_word,
  input  logic             cfg_wr_en,
  input  logic [VAL_W-1:0] cfg_wr_data
);

  cmd_t cmd;
  sts_t sts;

  lbrw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_mode   (in_word.mode),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  lbrw_datapath u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_word     (in_word),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .sts         (sts),
    .out_word    (out_word)
  );

endmodule

### verif/longest_bounded_range_window_check.sv
// Checker that predicts and compares the results of the bounded-range window block.
`timescale 1ns / 100ps

module longest_bounded_range_window_check import lbrw_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_ready,
  input  in_word_t         in_word,
  input  logic             out_valid,
  input  logic             out_ready,
  input  out_word_t        out_word,
  input  logic             cfg_wr_en,
  input  logic [VAL_W-1:0] cfg_wr_data,
  output int               fail_count,
  output int               pending
);

  // Shadow copy of the value store and the spread limit.
  logic [VAL_W-1:0] shadow_values [DEPTH];
  logic [VAL_W-1:0] shadow_limit;
  out_word_t        awaited_windows [$];

  // Furthest end reachable from start without exceeding the spread limit.
  function automatic int reach_end(int start, int stop);
    int lo;
    int hi;
    int e;
    int v;
    lo = int'(shadow_values[start]);
    hi = lo;
    e = start;
    while (e < stop) begin
      v = int'(shadow_values[e+1]);
      if (((v > hi) ? v : hi) - ((v < lo) ? v : lo) > int'(shadow_limit)) break;
      if (v < lo) lo = v;
      if (v > hi) hi = v;
      e++;
    end
    return e;
  endfunction

  // Earliest longest window inside the queried interval.
  function automatic out_word_t best_window(logic [IDX_W-1:0] left, logic [IDX_W-1:0] right_in);
    int right;
    int bs;
    int be;
    int j;
    int e;
    out_word_t w;
    right = int'(right_in);
    if (right > DEPTH - 1) right = DEPTH - 1;
    bs = int'(left);
    be = int'(left);
    if (int'(left) <= right) begin
      be = reach_end(bs, right);
      j = bs + 1;
      while (j <= right && be != right && right - j > be - bs) begin
        e = reach_end(j, right);
        if (e - j > be - bs) begin
          bs = j;
          be = e;
        end
        j++;
      end
    end
    w.window_start = IDX_W'(bs);
    w.window_end = IDX_W'(be);
    return w;
  endfunction

  // Track configuration, accepted words and returned results.
  always @(posedge clk) begin
    out_word_t exp_w;
    int errs;
    errs = 0;
    if (!rst_n) begin
      shadow_limit <= '0;
      awaited_windows.delete();
      fail_count <= 0;
    end else begin
      if (cfg_wr_en) shadow_limit <= cfg_wr_data;
      if (in_valid && in_ready) begin
        if (in_word.mode == MODE_WRITE) begin
          shadow_values[in_word.element_index] = in_word.element_value;
        end else begin
          awaited_windows = {awaited_windows,
                             best_window(in_word.query_left, in_word.query_right)};
        end
      end
      if (out_valid && out_ready) begin
        if (awaited_windows.size() == 0) begin
          $display("%0t: unexpected result start=%0d end=%0d", $time,
                   out_word.window_start, out_word.window_end);
          errs++;
        end else begin
          exp_w = awaited_windows.pop_front();
          if (exp_w.window_start !== out_word.window_start) begin
            $display("%0t: window_start expected %0d actual %0d", $time,
                     exp_w.window_start, out_word.window_start);
            errs++;
          end
          if (exp_w.window_end !== out_word.window_end) begin
            $display("%0t: window_end expected %0d actual %0d", $time,
                     exp_w.window_end, out_word.window_end);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
    end
    pending <= awaited_windows.size();
  end

endmodule

### verif/longest_bounded_range_window_core_test.sv
// Top of the testbench: stimulus, flow control and verdict for the window block.
`timescale 1ns / 100ps

module longest_bounded_range_window_core_test;
  import lbrw_pkg::*;

  localparam int RUN_LIMIT = 10000000;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  in_word_t         in_word = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  out_word_t        out_word;
  logic             cfg_wr_en = 1'b0;
  logic [VAL_W-1:0] cfg_wr_data = '0;
  int               fail_count;
  int               pending;

  // Stimulus bookkeeping: which entries have been written.
  bit stored [DEPTH];
  int stored_list [$];
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int hold_requests = 0;
  int word_count = 0;
  int cycle_count = 0;

  longest_bounded_range_window_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_word(in_word),
    .out_valid(out_valid), .out_ready(out_ready), .out_word(out_word),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  longest_bounded_range_window_check checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_word(in_word),
    .out_valid(out_valid), .out_ready(out_ready), .out_word(out_word),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .fail_count(fail_count), .pending(pending)
  );

  always #5 clk = ~clk;

  // Timeout guard.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= RUN_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Receiver flow control, with long hold-offs on request.
  always @(posedge clk) begin
    int hold_left;
    int holds_seen;
    if (holds_seen < hold_requests) begin
      holds_seen = holds_seen + 1;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= rst_n && ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // Offer one word and wait for it to be taken.
  task automatic send_word(in_word_t w);
    int gap;
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (!in_ready);
    word_count++;
  endtask

  task automatic write_element(int idx, logic [VAL_W-1:0] val);
    in_word_t w;
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    w = raw[$bits(in_word_t)-1:0];
    w.mode = MODE_WRITE;
    w.element_index = IDX_W'(idx);
    w.element_value = val;
    if (!stored[idx]) begin
      stored[idx] = 1'b1;
      stored_list = {stored_list, idx};
    end
    send_word(w);
  endtask

  task automatic ask_window(int left, int right);
    in_word_t w;
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    w = raw[$bits(in_word_t)-1:0];
    w.mode = MODE_QUERY;
    w.query_left = IDX_W'(left);
    w.query_right = IDX_W'(right);
    send_word(w);
  endtask

  // Write a run of consecutive entries, either close together or spread wide.
  task automatic write_run();
    int base;
    int len;
    int mid;
    bit near;
    base = $urandom_range(0, DEPTH - 1);
    len = $urandom_range(1, 16);
    near = $urandom_range(0, 3) != 0;
    mid = $urandom_range(0, (1 << 30) - 17);
    for (int i = base; i < base + len && i < DEPTH; i++) begin
      if (near) write_element(i, VAL_W'(mid + $urandom_range(0, 15)));
      else write_element(i, VAL_W'($urandom));
    end
  endtask

  // Query an interval made only of written entries, or an empty one.
  task automatic random_query();
    int anchor;
    int lo;
    int hi;
    int budget;
    int left;
    if ($urandom_range(0, 9) == 0) begin
      left = $urandom_range(1, DEPTH - 1);
      ask_window(left, $urandom_range(0, left - 1));
    end else begin
      anchor = stored_list[$urandom_range(0, stored_list.size() - 1)];
      budget = ($urandom_range(0, 19) == 0) ? 200 : 24;
      lo = anchor;
      hi = anchor;
      while (lo > 0 && stored[lo-1] && anchor - lo < budget) lo--;
      while (hi < DEPTH - 1 && stored[hi+1] && hi - anchor < budget) hi++;
      ask_window($urandom_range(lo, anchor), $urandom_range(anchor, hi));
    end
  endtask

  // Change the spread limit with the block idle.
  task automatic set_limit(logic [VAL_W-1:0] lim);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= lim;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    logic [VAL_W-1:0] limits [4];
    int wait_cycles;
    limits[0] = '0;
    limits[1] = VAL_W'(5);
    limits[2] = VAL_W'($urandom_range(0, 1 << 20));
    limits[3] = '1;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words: field extremes, empty interval, reset limit of zero.
    write_element(0, '0);
    write_element(1, '1);
    write_element(2, '1);
    write_element(3, '0);
    write_element(DEPTH - 1, '1);
    write_element(DEPTH - 2, '1);
    ask_window(0, 3);
    ask_window(1, 2);
    ask_window(DEPTH - 1, DEPTH - 1);
    ask_window(DEPTH - 2, DEPTH - 1);
    ask_window(DEPTH - 1, 0);
    ask_window(3, 3);
    ask_window(3, 2);
    set_limit('1);
    ask_window(0, 3);
    ask_window(DEPTH - 2, DEPTH - 1);
    write_element(4, VAL_W'(7));
    ask_window(0, 4);

    // Random phases, own spread limit each; last two share a flow-control mix.
    for (int p = 0; p < 4; p++) begin
      set_limit(limits[p]);
      case (p)
        0: begin
          tx_idle_pct = 23;
          rx_idle_pct = 53;
        end
        1: begin
          tx_idle_pct = 53;
          rx_idle_pct = 23;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      if (p == 0) hold_requests = hold_requests + 1;
      while (word_count < 18 + (p + 1) * 72) begin
        if ($urandom_range(0, 4) < 2) write_run();
        else random_query();
      end
    end

    // Drain and give the verdict.
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### longest_bounded_range_window_core.f
design/lbrw_pkg.sv
design/lbrw_datapath.sv
design/lbrw_ctrl.sv
design/longest_bounded_range_window_core.sv
verif/longest_bounded_range_window_check.sv
verif/longest_bounded_range_window_core_test.sv
